### rtl/sal_pkg.sv
// Shared types, constants and codes of the segment allocator.
package sal_pkg;

    localparam int MEM_SIZE = 1024;
    localparam int MAX_FREE_DEFAULT = 16;
    localparam int MAX_SEGS_DEFAULT = 16;

    localparam int AW = 10;   // address width
    localparam int SW = 11;   // segment size width
    localparam int EW = 12;   // width of start plus size sums
    localparam int PW = 8;    // cell position width, enough for 256 cells

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_FIND  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_BADID  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    typedef struct packed {
        logic [1:0]    kind;
        logic [3:0]    seg_id;
        logic [AW-1:0] start_req;
        logic [SW-1:0] size;
    } req_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] address;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t      op;
        logic [PW-1:0] pos;
        logic [AW-1:0] start;
        logic [SW-1:0] size;
    } cell_cmd_t;

endpackage

### rtl/sal_cell.sv
// One entry of the sorted free segment table, shifting with its neighbors.
module sal_cell #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sal_pkg::cell_cmd_t    cmd,
    input  logic [sal_pkg::AW-1:0] left_start,
    input  logic [sal_pkg::SW-1:0] left_size,
    input  logic [sal_pkg::AW-1:0] right_start,
    input  logic [sal_pkg::SW-1:0] right_size,
    output logic [sal_pkg::AW-1:0] start,
    output logic [sal_pkg::SW-1:0] size
);
    import sal_pkg::*;

    localparam logic [PW-1:0] MY_POS = PW'(IDX);
    localparam logic [SW-1:0] RST_SIZE = (IDX == 0) ? SW'(MEM_SIZE) : '0;

    logic [AW-1:0] start_reg, start_next;
    logic [SW-1:0] size_reg, size_next;
    logic          here;
    logic          above;

    assign here  = (cmd.pos == MY_POS);
    assign above = (MY_POS > cmd.pos);

    always_comb
    begin
        start_next = start_reg;
        size_next  = size_reg;
        unique case (cmd.op)
            CELL_WRITE:
            begin
                if (here)
                begin
                    start_next = cmd.start;
                    size_next  = cmd.size;
                end
            end
            CELL_INSERT:
            begin
                if (here)
                begin
                    start_next = cmd.start;
                    size_next  = cmd.size;
                end
                else if (above)
                begin
                    start_next = left_start;
                    size_next  = left_size;
                end
            end
            CELL_DELETE:
            begin
                if (here || above)
                begin
                    start_next = right_start;
                    size_next  = right_size;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            size_reg  <= RST_SIZE;
        end
        else
        begin
            start_reg <= start_next;
            size_reg  <= size_next;
        end
    end

    assign start = start_reg;
    assign size  = size_reg;

endmodule

### rtl/segment_allocator_free_list_unit.sv
// Top level of the segment allocator: controller, allocated table and cell chain.
//
//  channel | signals                   | direction | transaction
//  req     | req_valid, req_stall, req | in        | one request (kind, id, start, size)
//  rsp     | rsp_valid, rsp_stall, rsp | out       | one result (status, address)
//  cfg     | cfg_valid, cfg_ready, cfg_data | in   | write of fit_strategy
//
// One request at a time: the controller reads one cell of the chain per cycle while it scans
// the free table entries. Splits and double merges make a second chain shift in S_ACT2.
// After reset the first cell holds the whole memory and all ids are free.
// The result waits in an output register while rsp_stall is high; a new request is
// taken once the result has been loaded there.
module segment_allocator_free_list_unit #(
    parameter int MAX_FREE = sal_pkg::MAX_FREE_DEFAULT,
    parameter int MAX_SEGS = sal_pkg::MAX_SEGS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sal_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sal_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_data
);
    import sal_pkg::*;

    localparam int IW  = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
    localparam int CW  = $clog2(MAX_FREE + 1);
    localparam int SIW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam logic [8:0]    SEG_LIM = 9'(MAX_SEGS);
    localparam logic [CW-1:0] FULL    = CW'(MAX_FREE);
    localparam logic [EW-1:0] MEM_END = EW'(MEM_SIZE);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHK  = 6'b000010,
        S_SCAN = 6'b000100,
        S_ACT  = 6'b001000,
        S_ACT2 = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    logic [1:0]    fit_reg, fit_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          found_reg, found_next;
    logic [SW-1:0] pick_diff_reg, pick_diff_next;
    logic [AW-1:0] prev_start_reg, prev_start_next;
    logic [SW-1:0] prev_size_reg, prev_size_next;
    cell_cmd_t     cmd2_reg, cmd2_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;
    logic [MAX_SEGS-1:0] alloc_valid_reg, alloc_valid_next;

    logic [AW-1:0] alloc_start_mem [MAX_SEGS];
    logic [SW-1:0] alloc_size_mem [MAX_SEGS];
    logic [AW-1:0] rd_start_reg;
    logic [SW-1:0] rd_size_reg;
    logic          mem_we;

    logic [AW-1:0] entry_start [MAX_FREE];
    logic [SW-1:0] entry_size [MAX_FREE];
    cell_cmd_t     cell_cmd;

    logic [8:0]     id_ext;
    logic [SIW-1:0] seg_idx;
    logic           id_ok;
    logic [IW-1:0]  scan_idx;
    logic [8:0]     scan_ext, scan_dec_ext, scan_inc_ext;
    logic [AW-1:0]  cur_start;
    logic [SW-1:0]  cur_size;
    logic           in_range;
    logic           full;
    logic [EW-1:0]  s_e, n_e, end_e, cs, cz, fend, rs, rn, prev_end;
    logic [EW-1:0]  head_e, tail_e, both_e, mp_e, mn_e;
    logic [SW-1:0]  diff;
    logic           mp, mn;

    assign id_ext   = 9'(req_reg.seg_id);
    assign seg_idx  = id_ext[SIW-1:0];
    assign id_ok    = (id_ext < SEG_LIM);
    assign scan_idx = scan_reg[IW-1:0];
    assign scan_ext = 9'(scan_reg);
    assign scan_dec_ext = scan_ext - 9'd1;
    assign scan_inc_ext = scan_ext + 9'd1;
    assign cur_start = entry_start[scan_idx];
    assign cur_size  = entry_size[scan_idx];
    assign in_range  = (scan_reg < count_reg);
    assign full      = (count_reg >= FULL);

    assign s_e   = EW'(req_reg.start_req);
    assign n_e   = EW'(req_reg.size);
    assign end_e = s_e + n_e;
    assign cs    = EW'(cur_start);
    assign cz    = EW'(cur_size);
    assign fend  = cs + cz;
    assign rs    = EW'(rd_start_reg);
    assign rn    = EW'(rd_size_reg);
    assign prev_end = EW'(prev_start_reg) + EW'(prev_size_reg);
    assign head_e = s_e - cs;
    assign tail_e = fend - end_e;
    assign both_e = EW'(prev_size_reg) + rn + cz;
    assign mp_e   = EW'(prev_size_reg) + rn;
    assign mn_e   = cz + rn;
    assign diff   = cur_size - req_reg.size;
    assign mp     = (scan_reg != '0) && (prev_end == rs);
    assign mn     = in_range && ((rs + rn) == cs);

    // The chain of free table cells.
    genvar g;
    generate
        for (g = 0; g < MAX_FREE; g++)
        begin : g_cell
            sal_cell #(
                .IDX(g)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cell_cmd),
                .left_start  (entry_start[(g == 0) ? 0 : g - 1]),
                .left_size   (entry_size[(g == 0) ? 0 : g - 1]),
                .right_start (entry_start[(g == MAX_FREE - 1) ? g : g + 1]),
                .right_size  (entry_size[(g == MAX_FREE - 1) ? g : g + 1]),
                .start       (entry_start[g]),
                .size        (entry_size[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        fit_next        = fit_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        found_next      = found_reg;
        pick_diff_next  = pick_diff_reg;
        prev_start_next = prev_start_reg;
        prev_size_next  = prev_size_reg;
        cmd2_next       = cmd2_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        alloc_valid_next = alloc_valid_reg;
        mem_we          = 1'b0;
        cell_cmd        = '{op: CELL_HOLD, pos: '0, start: '0, size: '0};

        if (cfg_valid)
        begin
            fit_next = cfg_data;
        end
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    status_next = ST_OK;
                    addr_next   = '0;
                    scan_next   = '0;
                    found_next  = 1'b0;
                    state_next  = S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = S_SCAN;
                case (req_reg.kind)
                    KIND_ALLOC:
                    begin
                        if (!id_ok || alloc_valid_reg[seg_idx])
                        begin
                            status_next = ST_BADID;
                            state_next  = S_DONE;
                        end
                        else if (n_e == '0 || end_e > MEM_END)
                        begin
                            status_next = ST_NOFIT;
                            state_next  = S_DONE;
                        end
                    end
                    KIND_FREE:
                    begin
                        if (!id_ok || !alloc_valid_reg[seg_idx])
                        begin
                            status_next = ST_BADID;
                            state_next  = S_DONE;
                        end
                    end
                    KIND_FIND:
                    begin
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                scan_next = scan_reg + CW'(1);
                case (req_reg.kind)
                    KIND_ALLOC:
                    begin
                        if (!in_range)
                        begin
                            status_next = ST_NOFIT;
                            state_next  = S_DONE;
                        end
                        else if (cs <= s_e && end_e <= fend)
                        begin
                            scan_next  = scan_reg;
                            state_next = S_ACT;
                        end
                    end
                    KIND_FREE:
                    begin
                        if (in_range && cs < rs)
                        begin
                            prev_start_next = cur_start;
                            prev_size_next  = cur_size;
                        end
                        else
                        begin
                            scan_next  = scan_reg;
                            state_next = S_ACT;
                        end
                    end
                    default:
                    begin
                        if (!in_range)
                        begin
                            status_next = found_reg ? ST_OK : ST_NOFIT;
                            state_next  = S_DONE;
                        end
                        else if (cur_size >= req_reg.size)
                        begin
                            if (fit_reg == FIT_BEST)
                            begin
                                if (!found_reg || diff < pick_diff_reg)
                                begin
                                    found_next     = 1'b1;
                                    pick_diff_next = diff;
                                    addr_next      = cur_start;
                                end
                            end
                            else if (fit_reg == FIT_WORST)
                            begin
                                if (!found_reg || diff > pick_diff_reg)
                                begin
                                    found_next     = 1'b1;
                                    pick_diff_next = diff;
                                    addr_next      = cur_start;
                                end
                            end
                            else
                            begin
                                addr_next   = cur_start;
                                status_next = ST_OK;
                                state_next  = S_DONE;
                            end
                        end
                    end
                endcase
            end
            S_ACT:
            begin
                state_next = S_DONE;
                cell_cmd.pos = scan_ext[PW-1:0];
                if (req_reg.kind == KIND_ALLOC)
                begin
                    if (s_e == cs && end_e == fend)
                    begin
                        cell_cmd.op = CELL_DELETE;
                    end
                    else if (s_e == cs)
                    begin
                        cell_cmd.op    = CELL_WRITE;
                        cell_cmd.start = end_e[AW-1:0];
                        cell_cmd.size  = tail_e[SW-1:0];
                    end
                    else if (end_e == fend)
                    begin
                        cell_cmd.op    = CELL_WRITE;
                        cell_cmd.start = cur_start;
                        cell_cmd.size  = head_e[SW-1:0];
                    end
                    else if (!full)
                    begin
                        // Split: shrink the segment now, add the tail piece next cycle.
                        cell_cmd.op    = CELL_WRITE;
                        cell_cmd.start = cur_start;
                        cell_cmd.size  = head_e[SW-1:0];
                        cmd2_next = '{op: CELL_INSERT, pos: scan_inc_ext[PW-1:0],
                                      start: end_e[AW-1:0], size: tail_e[SW-1:0]};
                        state_next = S_ACT2;
                    end
                    if (!(s_e != cs && end_e != fend && full))
                    begin
                        mem_we = 1'b1;
                        alloc_valid_next[seg_idx] = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                else
                begin
                    if (mp && mn)
                    begin
                        cell_cmd.op    = CELL_WRITE;
                        cell_cmd.pos   = scan_dec_ext[PW-1:0];
                        cell_cmd.start = prev_start_reg;
                        cell_cmd.size  = both_e[SW-1:0];
                        cmd2_next = '{op: CELL_DELETE, pos: scan_ext[PW-1:0],
                                      start: '0, size: '0};
                        state_next = S_ACT2;
                    end
                    else if (mp)
                    begin
                        cell_cmd.op    = CELL_WRITE;
                        cell_cmd.pos   = scan_dec_ext[PW-1:0];
                        cell_cmd.start = prev_start_reg;
                        cell_cmd.size  = mp_e[SW-1:0];
                    end
                    else if (mn)
                    begin
                        cell_cmd.op    = CELL_WRITE;
                        cell_cmd.start = rd_start_reg;
                        cell_cmd.size  = mn_e[SW-1:0];
                    end
                    else if (!full)
                    begin
                        cell_cmd.op    = CELL_INSERT;
                        cell_cmd.start = rd_start_reg;
                        cell_cmd.size  = rd_size_reg;
                    end
                    if (mp || mn || !full)
                    begin
                        alloc_valid_next[seg_idx] = 1'b0;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
            end
            S_ACT2:
            begin
                cell_cmd   = cmd2_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.status  = status_reg;
                    rsp_next.address = (status_reg == ST_OK) ? addr_reg : '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cell_cmd.op == CELL_INSERT)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cell_cmd.op == CELL_DELETE)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fit_reg         <= FIT_FIRST;
            count_reg       <= CW'(1);
            rsp_valid_reg   <= 1'b0;
            alloc_valid_reg <= '0;
            found_reg       <= 1'b0;
            scan_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            fit_reg         <= fit_next;
            count_reg       <= count_next;
            rsp_valid_reg   <= rsp_valid_next;
            alloc_valid_reg <= alloc_valid_next;
            found_reg       <= found_next;
            scan_reg        <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        pick_diff_reg  <= pick_diff_next;
        prev_start_reg <= prev_start_next;
        prev_size_reg  <= prev_size_next;
        cmd2_reg       <= cmd2_next;
        rsp_reg        <= rsp_next;
    end

    // Allocated segment table: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            alloc_start_mem[seg_idx] <= req_reg.start_req;
            alloc_size_mem[seg_idx]  <= req_reg.size;
        end
        rd_start_reg <= alloc_start_mem[seg_idx];
        rd_size_reg  <= alloc_size_mem[seg_idx];
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

### rtl/sal_checker.sv
// Port-level checks of the segment allocator and their binding to the top level.
module sal_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input sal_pkg::rsp_t rsp
);
    import sal_pkg::*;

    // A held result keeps its value until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Only a successful find reports an address.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.address == '0)
        else $error("failed request carries an address");

    // Requests are worked one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while busy");

    // A new result only appears after a request has been worked.
    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without a request");

endmodule

bind segment_allocator_free_list_unit sal_checker u_sal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
